// File: rtl/oaps_pkg.sv
// Shared constants and types for the overlap-add pitch shifter.
`timescale 1ns / 1ps
package oaps_pkg;

  localparam int unsigned DEF_MAX_WINDOW = 8192;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 15;
  localparam int unsigned COEF_IDX_W = 13;
  localparam int unsigned FILL_W     = 13;
  localparam int unsigned WIN_LEN_W  = 14;
  localparam int unsigned SHIFT_W    = 15;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

  // Request kinds on the input channel.
  localparam logic REQ_AUDIO = 1'b0;
  localparam logic REQ_COEF  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LEN = 1'b1;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST   = 14'd1024;
  localparam logic [SHIFT_W-1:0]   SHIFT_LEN_RST = 15'd1024;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_OUT  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Status of the block engine toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

// File: rtl/oaps_ifs.sv
// Valid/ready channel interfaces for the pitch shifter input and result words.
`timescale 1ns / 1ps
interface oaps_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] sample;
  logic [12:0] coef_index;
  logic [14:0] coef_value;
  modport source (output valid, req_type, sample, coef_index, coef_value, input ready);
  modport sink (input valid, req_type, sample, coef_index, coef_value, output ready);
endinterface

interface oaps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_sample;
  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

// File: rtl/oaps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module oaps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/oaps_blk.sv
// Block engine: walks the window, resamples history, multiplies and writes sums and carries.
`timescale 1ns / 1ps
module oaps_blk import oaps_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_WINDOW)+1:0]       win_eff,
  input  logic [$clog2(MAX_WINDOW)+1:0]       shift_eff,
  input  logic [$clog2(2*MAX_WINDOW)-1:0]     hist_pos,
  input  logic [$clog2(2*MAX_WINDOW):0]       hist_fill,
  input  logic [$clog2(MAX_WINDOW/2):0]       carry_hi,
  input  logic [SAMPLE_W-1:0]                 hist_rdata,
  input  logic [COEF_W-1:0]                   win_rdata,
  input  logic [SAMPLE_W-1:0]                 carry_rdata,
  output logic                                rd_en,
  output logic [$clog2(2*MAX_WINDOW)-1:0]     hist_raddr,
  output logic [$clog2(MAX_WINDOW)-1:0]       win_raddr,
  output logic [$clog2(MAX_WINDOW/2)-1:0]     carry_raddr,
  output logic                                pend_we,
  output logic [$clog2(MAX_WINDOW/2)-1:0]     pend_waddr,
  output logic [SAMPLE_W-1:0]                 pend_wdata,
  output logic                                carry_we,
  output logic [$clog2(MAX_WINDOW/2)-1:0]     carry_waddr,
  output logic [SAMPLE_W-1:0]                 carry_wdata,
  output eng_stat_t                           stat
);

  localparam int unsigned AW  = $clog2(MAX_WINDOW);
  localparam int unsigned HAW = $clog2(2*MAX_WINDOW);
  localparam int unsigned PAW = $clog2(MAX_WINDOW/2);
  localparam int unsigned CW  = $clog2(MAX_WINDOW) + 2;
  localparam int unsigned HD  = 2 * MAX_WINDOW;

  logic          busy_r, act_r;
  logic [CW-1:0] x_r, off_r, rem_r;
  logic [CW-1:0] x_nxt, off_nxt, rem_nxt;
  logic [CW-1:0] half;
  logic [CW:0]   step_sum, two_w;

  logic [HAW+1:0] idx_sum, idx_wrap;
  logic           hv, cv, lo_ph;

  // Stage 1 tags travel with the RAM read.
  logic          v1_r, ph1_r, hv1_r, cv1_r;
  logic [CW-1:0] x1_r;
  // Stage 2 holds the product.
  logic                 v2_r, ph2_r;
  logic [CW-1:0]        x2_r;
  logic signed [31:0]   prod_r;
  logic [SAMPLE_W-1:0]  cin_r;

  logic signed [31:0]   prod;
  logic [16:0]          q_shift;
  logic [SAMPLE_W-1:0]  q;
  logic [CW-1:0]        cidx;

  assign half  = win_eff >> 1;
  assign two_w = {win_eff, 1'b0};

  // Running offset floor(x*S/W) kept as quotient and remainder.
  always_comb begin
    step_sum = (CW+1)'(rem_r) + (CW+1)'(shift_eff);
    x_nxt    = x_r + CW'(1);
    if (step_sum >= two_w) begin
      rem_nxt = CW'(step_sum - two_w);
      off_nxt = off_r + CW'(2);
    end else if (step_sum >= (CW+1)'(win_eff)) begin
      rem_nxt = CW'(step_sum - (CW+1)'(win_eff));
      off_nxt = off_r + CW'(1);
    end else begin
      rem_nxt = CW'(step_sum);
      off_nxt = off_r;
    end
  end

  // History address of the resampled tap, wrapped into the ring.
  always_comb begin
    idx_sum  = (HAW+2)'(hist_pos) + (HAW+2)'(HD) - (HAW+2)'(shift_eff) + (HAW+2)'(off_r);
    idx_wrap = (idx_sum >= (HAW+2)'(HD)) ? idx_sum - (HAW+2)'(HD) : idx_sum;
    hv       = ((HAW+1)'(idx_wrap) < hist_fill);
    lo_ph    = (x_r < half);
    cv       = ((CW+1)'(x_r) < (CW+1)'(carry_hi));
  end

  assign rd_en       = act_r;
  assign hist_raddr  = HAW'(idx_wrap);
  assign win_raddr   = AW'(x_r);
  assign carry_raddr = PAW'(x_r);

  // Issue counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      act_r  <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      act_r  <= 1'b1;
    end else begin
      if (act_r && x_r == win_eff - CW'(1)) begin
        act_r <= 1'b0;
      end
      if (stat.done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= '0;
      off_r <= '0;
      rem_r <= '0;
    end else if (act_r) begin
      x_r   <= x_nxt;
      off_r <= off_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= act_r;
      v2_r <= v1_r;
    end
  end

  // Multiply stage: history tap times window coefficient.
  assign prod = $signed(hv1_r ? hist_rdata : SAMPLE_W'(0)) * $signed({1'b0, win_rdata});

  always_ff @(posedge clk) begin
    x1_r   <= x_r;
    ph1_r  <= lo_ph;
    hv1_r  <= hv;
    cv1_r  <= cv && lo_ph;
    x2_r   <= x1_r;
    ph2_r  <= ph1_r;
    prod_r <= prod;
    cin_r  <= cv1_r ? carry_rdata : '0;
  end

  // Divide by 32768 rounding toward zero, then write the sum or the new carry.
  always_comb begin
    q_shift = 17'(prod_r >>> 15);
    if (prod_r[31] && (prod_r[14:0] != '0)) begin
      q_shift = q_shift + 17'd1;
    end
    q    = q_shift[SAMPLE_W-1:0];
    cidx = x2_r - half;
  end

  assign pend_we     = v2_r && ph2_r;
  assign pend_waddr  = PAW'(x2_r);
  assign pend_wdata  = (cin_r + q) ^ SIGN_FLIP;
  assign carry_we    = v2_r && !ph2_r;
  assign carry_waddr = PAW'(cidx);
  assign carry_wdata = q;

  assign stat.busy = busy_r;
  assign stat.done = busy_r && !start && !act_r && !v1_r && !v2_r;

endmodule

// File: rtl/overlap_add_pitch_shifter_unit.sv
// Top level of the overlap-add pitch shifter: control sequencer and memories.
// A word's result is read from pending RAM in ST_OUT and then goes to the output register, or
// to the second one while the first waits. Words are taken only in ST_IDLE; every W/2-th word
// adds a block pass in ST_FIN, set by the single shared multiplier taking one window tap a
// cycle. A second output register keeps one waiting result from stalling the input. Reset:
// synchronous, active low; no clearing pass, fill counts make unwritten history, carry and
// pending entries read as zero, so the block accepts words right after reset.
`timescale 1ns / 1ps
module overlap_add_pitch_shifter_unit import oaps_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  oaps_in_if.sink               in_word,
  oaps_out_if.source            out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW   = $clog2(MAX_WINDOW);
  localparam int unsigned HAW  = $clog2(2*MAX_WINDOW);
  localparam int unsigned PAW  = $clog2(MAX_WINDOW/2);
  localparam int unsigned CW   = $clog2(MAX_WINDOW) + 2;
  localparam int unsigned XW   = ((CW > 15) ? CW : 15) + 1;
  localparam int unsigned HD   = 2 * MAX_WINDOW;
  localparam int unsigned HALF = MAX_WINDOW / 2;

  state_t state_r;

  logic [WIN_LEN_W-1:0] win_len_r;
  logic [SHIFT_W-1:0]   shift_len_r;
  logic [XW-1:0]        w_ext, s_ext, w_sat;
  logic [CW-1:0]        win_eff, shift_eff, half;

  logic [FILL_W-1:0]   fc_r, fc_inc;
  logic                flag_r, emit_r, fin_r, pend_ok_r, pend_in_r;
  logic [HAW-1:0]      hist_pos_r;
  logic [HAW:0]        hist_fill_r;
  logic [PAW:0]        pend_hi_r, carry_hi_r, half_p;
  logic                out_valid_r, out_valid_nxt, skid_v_r, skid_v_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic                new_v;
  logic [SAMPLE_W-1:0] new_d;

  logic in_acc, audio_acc, coef_acc, start;

  logic                 rd_en, pend_we, carry_we;
  logic [HAW-1:0]       hist_raddr;
  logic [AW-1:0]        win_raddr;
  logic [PAW-1:0]       carry_raddr, pend_waddr, carry_waddr;
  logic [SAMPLE_W-1:0]  pend_wdata, carry_wdata, hist_rdata, carry_rdata, pend_rdata;
  logic [COEF_W-1:0]    win_rdata;
  eng_stat_t            stat;

  // Effective window and shift lengths, evened and saturated.
  always_comb begin
    w_ext = XW'({win_len_r[WIN_LEN_W-1:1], 1'b0});
    w_sat = w_ext;
    if (w_sat > XW'(MAX_WINDOW & ~1)) begin
      w_sat = XW'(MAX_WINDOW & ~1);
    end
    if (w_sat < XW'(2)) begin
      w_sat = XW'(2);
    end
    s_ext = XW'({shift_len_r[SHIFT_W-1:1], 1'b0});
    if (s_ext < XW'(2)) begin
      s_ext = XW'(2);
    end
    if (s_ext > (w_sat << 1)) begin
      s_ext = w_sat << 1;
    end
    win_eff   = CW'(w_sat);
    shift_eff = CW'(s_ext);
    half      = win_eff >> 1;
    half_p    = (PAW+1)'(half);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WIN_LEN_RST;
      shift_len_r <= SHIFT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_LEN:   win_len_r   <= cfg_wdata[WIN_LEN_W-1:0];
        CFG_SHIFT_LEN: shift_len_r <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: take a word when idle and the second output register is free.
  assign in_word.ready = (state_r == ST_IDLE) && !skid_v_r;
  assign in_acc    = in_word.valid && in_word.ready;
  assign audio_acc = in_acc && (in_word.req_type == REQ_AUDIO);
  assign coef_acc  = in_acc && (in_word.req_type == REQ_COEF);
  assign fc_inc    = fc_r + FILL_W'(1);
  assign start     = (state_r == ST_OUT) && fin_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fc_r        <= '0;
      flag_r      <= 1'b0;
      emit_r      <= 1'b0;
      fin_r       <= 1'b0;
      pend_ok_r   <= 1'b0;
      pend_in_r   <= 1'b0;
      hist_pos_r  <= '0;
      hist_fill_r <= '0;
      pend_hi_r   <= '0;
      carry_hi_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (audio_acc) begin
            emit_r    <= flag_r;
            pend_in_r <= (XW'(fc_r) < XW'(HALF));
            pend_ok_r <= (XW'(fc_r) < XW'(HALF)) && (XW'(fc_r) < XW'(pend_hi_r));
            fin_r     <= (XW'(fc_inc) >= XW'(half));
            fc_r      <= fc_inc;
            hist_pos_r <= (hist_pos_r == HAW'(HD - 1)) ? '0 : hist_pos_r + HAW'(1);
            if (hist_fill_r != (HAW+1)'(HD)) begin
              hist_fill_r <= hist_fill_r + (HAW+1)'(1);
            end
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (fin_r) begin
            fc_r    <= '0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (stat.done) begin
            flag_r <= 1'b1;
            if (half_p > pend_hi_r) begin
              pend_hi_r <= half_p;
            end
            if (half_p > carry_hi_r) begin
              carry_hi_r <= half_p;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result word of the current audio word; unwritten pending entries read as zero.
  assign new_v = (state_r == ST_OUT) && emit_r;
  assign new_d = pend_ok_r ? pend_rdata : (pend_in_r ? '0 : SIGN_FLIP);

  // Two-deep output: the second register holds a word while the first waits.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_v_nxt    = skid_v_r;
    skid_data_nxt = skid_data_r;
    if (out_valid_r && out_word.ready) begin
      out_valid_nxt = skid_v_r;
      out_data_nxt  = skid_data_r;
      skid_v_nxt    = 1'b0;
    end
    if (new_v) begin
      if (out_valid_nxt) begin
        skid_v_nxt    = 1'b1;
        skid_data_nxt = new_d;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = new_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.out_sample = out_data_r;

  // Sample history ring.
  oaps_ram #(.WIDTH(SAMPLE_W), .DEPTH(HD)) u_hist (
    .clk   (clk),
    .we    (audio_acc),
    .waddr (hist_pos_r),
    .wdata (in_word.sample ^ SIGN_FLIP),
    .re    (rd_en),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Window coefficient table.
  oaps_ram #(.WIDTH(COEF_W), .DEPTH(MAX_WINDOW)) u_win (
    .clk   (clk),
    .we    (coef_acc && (XW'(in_word.coef_index) < XW'(MAX_WINDOW))),
    .waddr (AW'(in_word.coef_index)),
    .wdata (in_word.coef_value),
    .re    (rd_en),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // Overlap carry.
  oaps_ram #(.WIDTH(SAMPLE_W), .DEPTH(HALF)) u_carry (
    .clk   (clk),
    .we    (carry_we),
    .waddr (carry_waddr),
    .wdata (carry_wdata),
    .re    (rd_en),
    .raddr (carry_raddr),
    .rdata (carry_rdata)
  );

  // Pending output words of the finished block.
  oaps_ram #(.WIDTH(SAMPLE_W), .DEPTH(HALF)) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (audio_acc),
    .raddr (PAW'(fc_r)),
    .rdata (pend_rdata)
  );

  // Block engine.
  oaps_blk #(.MAX_WINDOW(MAX_WINDOW)) u_blk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .win_eff     (win_eff),
    .shift_eff   (shift_eff),
    .hist_pos    (hist_pos_r),
    .hist_fill   (hist_fill_r),
    .carry_hi    (carry_hi_r),
    .hist_rdata  (hist_rdata),
    .win_rdata   (win_rdata),
    .carry_rdata (carry_rdata),
    .rd_en       (rd_en),
    .hist_raddr  (hist_raddr),
    .win_raddr   (win_raddr),
    .carry_raddr (carry_raddr),
    .pend_we     (pend_we),
    .pend_waddr  (pend_waddr),
    .pend_wdata  (pend_wdata),
    .carry_we    (carry_we),
    .carry_waddr (carry_waddr),
    .carry_wdata (carry_wdata),
    .stat        (stat)
  );

endmodule
